// ===== rtl/rtcc_pkg.sv =====
// Shared types, constants and table functions for the RTC calendar converter.
// No dependencies; imported by rtcc_field_check and rtc_calendar_to_utc_seconds.

package rtcc_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FIELD = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    localparam int unsigned YEAR_LO      = 2000;
    localparam int unsigned YEAR_HI      = 2099;
    localparam logic signed [10:0] OFFSET_RESET = 11'sd480;

    // Supported UTC window, 2024-01-01 .. 2099-12-31 end of day
    localparam logic signed [34:0] UTC_MIN = 35'sd1704067200;
    localparam logic signed [34:0] UTC_MAX = 35'sd4102444799;

    localparam int DAYS_PER_ERA = 146097;
    localparam int EPOCH_SHIFT  = 719468;
    localparam int SECS_PER_DAY = 86400;

    // Era 5 covers 2000..2399, era 4 covers the shifted year 1999
    localparam logic signed [20:0] ERA5_BIAS = 21'(5 * DAYS_PER_ERA - EPOCH_SHIFT);
    localparam logic signed [20:0] ERA4_BIAS = 21'(4 * DAYS_PER_ERA - EPOCH_SHIFT);

    // Length of a month (1..12); zero for codes that are no month
    function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
        logic [4:0] n;
        begin
            case (month)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
                4'd2:                                      n = leap ? 5'd29 : 5'd28;
                default:                                   n = 5'd0;
            endcase
            return n;
        end
    endfunction

    // Day of year at the start of a March-based month: (153*mp + 2) / 5
    function automatic logic [8:0] month_day_base(input logic [3:0] mp);
        logic [8:0] b;
        begin
            case (mp)
                4'd0:    b = 9'd0;
                4'd1:    b = 9'd31;
                4'd2:    b = 9'd61;
                4'd3:    b = 9'd92;
                4'd4:    b = 9'd122;
                4'd5:    b = 9'd153;
                4'd6:    b = 9'd184;
                4'd7:    b = 9'd214;
                4'd8:    b = 9'd245;
                4'd9:    b = 9'd275;
                4'd10:   b = 9'd306;
                4'd11:   b = 9'd337;
                default: b = 9'd0;
            endcase
            return b;
        end
    endfunction

endpackage

// ===== rtl/rtcc_field_check.sv =====
// Range check of one calendar reading (year, month, day, time of day).
// Depends on rtcc_pkg for the month length table and year limits.

module rtcc_field_check
    import rtcc_pkg::*;
(
    input  logic [11:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    output logic        fields_ok
);

    logic       year_ok;
    logic       leap;
    logic [4:0] mdays;

    // Within 2000..2099 the leap rule reduces to divisibility by four
    assign year_ok = (year >= 12'(YEAR_LO)) && (year <= 12'(YEAR_HI));
    assign leap    = (year[1:0] == 2'b00);
    assign mdays   = days_in_month(month, leap);

    assign fields_ok = year_ok && (mdays != 5'd0) && (day != 5'd0) && (day <= mdays)
                    && (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59);

endmodule

// ===== rtl/rtc_calendar_to_utc_seconds.sv =====
// Top level: calendar reading to UTC seconds, four-stage pipeline.
// Depends on rtcc_pkg and rtcc_field_check.

// One request is taken on every cycle that start is high; busy is never raised.
// Each request yields exactly one result, marked by done, after it passes the v1,
// v2, v3 and done registers (stages: field check and day-of-year lookup, day count and time of
// day, day-to-seconds multiply, offset subtract and range check). The receiver
// cannot stall, so results leave at the input rate. status 0 gives utc_seconds,
// status 1 flags a bad calendar field, status 2 a time outside 2024..2099 UTC;
// utc_seconds is zero for both errors. Write the UTC offset register only with no
// request in flight.

module rtc_calendar_to_utc_seconds
    import rtcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    input  logic        wr_en,
    input  logic [10:0] wr_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] utc_seconds
);

    // Offset register
    logic signed [10:0] offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= OFFSET_RESET;
        else if (wr_en)
            offset_reg <= wr_data;
    end

    assign busy = 1'b0;

    // Stage 0 (comb): field check, shifted year, day of year
    logic        fields_ok;
    logic [11:0] y_shift;
    logic        era5_next;
    logic [8:0]  yoe_next;
    logic [3:0]  mp;
    logic [8:0]  doy_next;

    rtcc_field_check u_check (
        .year      (year),
        .month     (month),
        .day       (day),
        .hour      (hour),
        .minute    (minute),
        .second    (second),
        .fields_ok (fields_ok)
    );

    assign y_shift   = year - ((month <= 4'd2) ? 12'd1 : 12'd0);
    assign era5_next = (y_shift >= 12'(YEAR_LO));
    assign yoe_next  = era5_next ? 9'(y_shift - 12'(YEAR_LO)) : 9'd399;
    assign mp        = (month > 4'd2) ? (month - 4'd3) : (month + 4'd9);
    assign doy_next  = month_day_base(mp) + 9'(day) - 9'd1;

    logic        v1_reg;
    logic        ok1_reg;
    logic        era5_1_reg;
    logic [8:0]  yoe1_reg;
    logic [8:0]  doy1_reg;
    logic [4:0]  hour1_reg;
    logic [5:0]  min1_reg;
    logic [5:0]  sec1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        ok1_reg    <= fields_ok;
        era5_1_reg <= era5_next;
        yoe1_reg   <= yoe_next;
        doy1_reg   <= doy_next;
        hour1_reg  <= hour;
        min1_reg   <= minute;
        sec1_reg   <= second;
    end

    // Stage 1: days since 1970 and seconds into the day
    logic signed [20:0] doe;
    logic signed [20:0] day_count;
    logic [16:0]        tod_next;
    logic [1:0]         cent;

    assign cent      = era5_1_reg ? 2'd0 : 2'd3;
    assign doe       = 21'(yoe1_reg) * 21'sd365 + 21'(yoe1_reg[8:2]) - 21'(cent)
                     + 21'(doy1_reg);
    assign day_count = doe + (era5_1_reg ? ERA5_BIAS : ERA4_BIAS);
    assign tod_next  = 17'(hour1_reg) * 17'd3600 + 17'(min1_reg) * 17'd60 + 17'(sec1_reg);

    logic        v2_reg;
    logic        ok2_reg;
    logic [15:0] days2_reg;
    logic [16:0] tod2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        ok2_reg   <= ok1_reg;
        days2_reg <= day_count[15:0];
        tod2_reg  <= tod_next;
    end

    // Stage 2: days to seconds
    logic        v3_reg;
    logic        ok3_reg;
    logic [32:0] dsec3_reg;
    logic [16:0] tod3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        ok3_reg   <= ok2_reg;
        dsec3_reg <= 33'(days2_reg) * 33'(SECS_PER_DAY);
        tod3_reg  <= tod2_reg;
    end

    // Stage 3: subtract offset, range check, result register
    logic signed [16:0] off_secs;
    logic signed [34:0] utc_full;
    logic               in_range;
    status_t            status_next;
    logic [31:0]        utc_next;

    assign off_secs = 17'(offset_reg) * 17'sd60;
    assign utc_full = $signed({2'b00, dsec3_reg}) + $signed({18'd0, tod3_reg})
                    - 35'(off_secs);
    assign in_range = (utc_full >= UTC_MIN) && (utc_full <= UTC_MAX);

    always_comb
    begin
        status_next = STATUS_OK;
        utc_next    = 32'd0;
        if (!ok3_reg)
            status_next = STATUS_FIELD;
        else if (!in_range)
            status_next = STATUS_RANGE;
        else
            utc_next = utc_full[31:0];
    end

    logic        done_reg;
    status_t     status_reg;
    logic [31:0] utc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        utc_reg    <= utc_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign utc_seconds = utc_reg;

    // Checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 done)
        else $error("request did not produce a result four cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("result without a matching request");

    a_ok_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_OK) |-> (utc_seconds >= 32'd1704067200))
        else $error("accepted time below supported window");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (utc_seconds == 32'd0))
        else $error("error result carries nonzero seconds");

endmodule
